// ===== rtl/lsp_pkg.sv =====
// Package for the line sign priority table: sizes, operation codes,
// controller states and the result type. No dependencies.
package lsp_pkg;

   localparam int ENTRIES = 64;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int LINE_W  = 32;
   localparam int MARK_W  = 3;
   localparam int ROW_W   = LINE_W + MARK_W;

   localparam logic [MARK_W-1:0] MARK_NONE = '0;

   typedef enum logic {
      OP_INCLUDE = 1'b0,
      OP_LOOKUP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MARK_W-1:0] found_kind;
      logic              table_full;
   } result_type;

endpackage

// ===== rtl/lsp_req_if.sv =====
// Request channel of the line sign priority table.
// Depends on lsp_pkg for field widths.
interface lsp_req_if import lsp_pkg::*;;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [LINE_W-1:0] line;
   logic [MARK_W-1:0] sign_kind;

   modport source (output valid, kind, line, sign_kind, input ready);
   modport sink   (input valid, kind, line, sign_kind, output ready);
endinterface

// ===== rtl/lsp_rsp_if.sv =====
// Response channel of the line sign priority table.
// Depends on lsp_pkg for field widths.
interface lsp_rsp_if import lsp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MARK_W-1:0] found_kind;
   logic              table_full;

   modport source (output valid, found_kind, table_full, input ready);
   modport sink   (input valid, found_kind, table_full, output ready);
endinterface

// ===== rtl/lsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/line_sign_priority_table.sv =====
// Top level of the line sign priority table: a controller that scans a
// row RAM of {line, mark} entries. Depends on lsp_pkg, lsp_req_if,
// lsp_rsp_if and lsp_ram.
//
//   channel   role    fields
//   req_chan  sink    kind, line, sign_kind
//   rsp_chan  source  found_kind, table_full
//
// Entries fill from row 0 upward, so the held entries are the rows below
// the fill count. A transaction runs through accept, one RAM read per held
// entry up to the first match on the single read port, then the hand-off
// to the response register. An empty table or an include with mark none
// goes from accept straight to the hand-off. Reset clears state, fill
// count and response valid; the RAM needs no clearing. A stalled response
// holds the controller in its hand-off state while a new request waits.
module line_sign_priority_table import lsp_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   lsp_req_if.sink   req_chan,
   lsp_rsp_if.source rsp_chan
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   op_type            op_ff, op_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [MARK_W-1:0] code_ff, code_in;
   result_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ROW_W-1:0]  ram_rdata;

   logic [LINE_W-1:0] rd_line;
   logic [MARK_W-1:0] rd_mark;
   logic              rd_match;
   logic              rd_last;
   logic              has_room;
   logic              req_fire;

   assign rd_line  = ram_rdata[ROW_W-1:MARK_W];
   assign rd_mark  = ram_rdata[MARK_W-1:0];
   assign rd_match = (rd_line == line_ff);
   assign rd_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign has_room = (count_ff < CNT_W'(ENTRIES));
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found_kind = rsp_ff.found_kind;
   assign rsp_chan.table_full = rsp_ff.table_full;

   lsp_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ENTRIES)
   ) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Next state, RAM access and result
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      line_in      = line_ff;
      code_in      = code_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = {line_ff, code_ff};
      ram_raddr    = '0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = op_type'(req_chan.kind);
               line_in = req_chan.line;
               code_in = req_chan.sign_kind;
               idx_in  = '0;
               res_in  = '0;
               if (op_type'(req_chan.kind) == OP_INCLUDE
                   && req_chan.sign_kind == MARK_NONE) begin
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  // empty table: a lookup misses, an include takes row 0
                  if (op_type'(req_chan.kind) == OP_INCLUDE) begin
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     ram_wdata = {req_chan.line, req_chan.sign_kind};
                     count_in  = CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  // read row 0; its data arrives in the first scan cycle
                  ram_raddr = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            ram_raddr = idx_ff + ADDR_W'(1);
            if (rd_match) begin
               if (op_ff == OP_LOOKUP) begin
                  res_in.found_kind = rd_mark;
               end else if (code_ff < rd_mark) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
               end
               state_in = ST_DONE;
            end else if (rd_last) begin
               if (op_ff == OP_INCLUDE) begin
                  if (has_room) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[ADDR_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     res_in.table_full = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end

         ST_DONE: begin
            // hand off once the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      op_ff   <= op_in;
      line_ff <= line_in;
      code_ff <= code_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule
